// ===== hdl/e00ld_pkg.sv =====
package e00ld_pkg;

  // default depth of the digit pair buffer
  localparam int DIGIT_PAIRS_DEF = 24;

  // character codes
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SUB     = 8'd26;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_BANG    = 8'd33;
  localparam logic [7:0] CH_PAREN   = 8'd40;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_E       = 8'd69;
  localparam logic [7:0] CH_PIPE    = 8'd124;
  localparam logic [7:0] CH_CLOSE   = 8'd125;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] RUN_MAX    = 8'd126;

  // number header layout
  localparam int HDR_GROUP  = 15;
  localparam int ODD_SPLIT  = 45;
  localparam int HDR_SPAN   = 90;
  localparam int HDR_GROUPS = HDR_SPAN / HDR_GROUP;
  localparam int EXP_MODES  = ODD_SPLIT / HDR_GROUP;

  // high digit pairs follow a close brace
  localparam logic [6:0] PAIR_HI_BASE = 7'd92;

  localparam logic [6:0] LINE_LIMIT_RESET = 7'd80;

  // register byte addresses
  localparam logic [1:0] ADDR_LINE_LIMIT = 2'd0;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LONG = 2'd1;
  localparam logic [1:0] ERR_ESC  = 2'd2;
  localparam logic [1:0] ERR_NUM  = 2'd3;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_RUN,
    MODE_NUM,
    MODE_NUMHI,
    MODE_TAIL,
    MODE_TAILRUN
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT,
    S_ERR,
    S_EXPAND,
    S_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_E,
    PH_SIGN,
    PH_EXP,
    PH_SPACE
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_RESULT,
    ACT_EMIT,
    ACT_EXPAND
  } act_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [6:0] rep;
    logic       eol;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic valid;
    logic end_req;
  } gen_ctl_t;

  typedef struct packed {
    logic taken;
    logic flushed;
  } gen_ack_t;

  typedef struct packed {
    logic [6:0] grant;
    logic       fits;
    logic [6:0] length_next;
  } emit_t;

  typedef struct packed {
    logic [3:0] pp;
    logic       odd;
    logic [1:0] expm;
  } hdr_t;

  typedef struct packed {
    act_t       act;
    res_t       res;
    mode_t      mode_next;
    logic [1:0] raise;
    logic [7:0] emit_ch;
    logic [6:0] emit_k;
    logic       hdr_load;
    logic       pair_wr;
    logic [6:0] pair_val;
    logic       line_clear;
    logic       term_space;
  } dec_t;

  // split a header code into point position, odd flag and exponent mode
  function automatic hdr_t hdr_split(input logic [6:0] n);
    logic [2:0] q;
    logic [6:0] base;
    hdr_t       h;
    q = 3'd0;
    for (int i = 1; i < HDR_GROUPS; i++) begin
      if (n >= 7'(i * HDR_GROUP)) q = 3'(i);
    end
    base   = 7'(q) * 7'(HDR_GROUP);
    h.pp   = 4'(n - base);
    h.odd  = (n >= 7'(ODD_SPLIT));
    h.expm = (q >= 3'(EXP_MODES)) ? 2'(q - 3'(EXP_MODES)) : 2'(q);
    return h;
  endfunction

  // tens digit of a pair value 0..99, reciprocal multiply
  function automatic logic [3:0] pair_tens(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'(205);
    return p[14:11];
  endfunction

endpackage

// ===== hdl/e00ld_emit_unit.sv =====
module e00ld_emit_unit (
  input  logic [6:0]      line_length,
  input  logic [6:0]      line_limit,
  input  logic [6:0]      k,
  output e00ld_pkg::emit_t eu
);
  import e00ld_pkg::*;

  logic [6:0] room;

  // room left on the line, a request is cut to it
  always_comb begin
    room           = (line_length < line_limit) ? (line_limit - line_length) : 7'd0;
    eu.fits        = (k <= room);
    eu.grant       = eu.fits ? k : room;
    eu.length_next = line_length + eu.grant;
  end

endmodule

// ===== hdl/e00ld_out_stage.sv =====
module e00ld_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  e00ld_pkg::gen_ctl_t ctl,
  input  e00ld_pkg::res_t     gen_res,
  output e00ld_pkg::gen_ack_t ack,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic [6:0]          repeat_res,
  output logic                end_of_line,
  output logic [1:0]          error_code,
  output logic                last
);
  import e00ld_pkg::*;

  logic pend_valid;
  res_t pend;
  res_t out_res;
  logic out_last;
  logic out_free;
  logic load_out;
  logic last_in;

  assign out_free = !out_valid || out_ready;

  // one result is held back until the next one or the end of the byte
  // shows whether it is the final one
  always_comb begin
    ack      = '0;
    load_out = 1'b0;
    last_in  = 1'b0;
    if (ctl.valid) begin
      if (!pend_valid) begin
        ack.taken = 1'b1;
      end else if (out_free) begin
        ack.taken = 1'b1;
        load_out  = 1'b1;
      end
    end else if (ctl.end_req) begin
      if (!pend_valid) begin
        ack.flushed = 1'b1;
      end else if (out_free) begin
        ack.flushed = 1'b1;
        load_out    = 1'b1;
        last_in     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ack.taken) begin
        pend_valid <= 1'b1;
      end else if (ack.flushed) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res  <= pend;
      out_last <= last_in;
    end
    if (ack.taken) begin
      pend <= gen_res;
    end
  end

  assign out_char    = out_res.ch;
  assign repeat_res  = out_res.rep;
  assign end_of_line = out_res.eol;
  assign error_code  = out_res.err;
  assign last        = out_last;

endmodule

// ===== hdl/e00_line_decompressor.sv =====
// channel     direction  handshake                     payload
// config      in/out     psel penable pwrite pready    paddr pwdata prdata (line_limit)
// in          in         in_valid  in_ready            in_byte
// out         out        out_valid out_ready           out_char repeat_res end_of_line
//                                                      error_code last
//
// one byte at a time, in_ready only in idle; a byte is decoded, then a character or
// run is emitted, cut at the line limit with an overflow error after it, or a number
// is expanded digit by digit, and each byte ends with a flush of the hold stage
// results pass a one-deep hold stage that marks the last transfer of a byte, then
// an output register; with both full the sequencer stalls
// rst is synchronous, clears mode, line length and sticky error, line_limit to 80
module e00_line_decompressor #(
  parameter int DIGIT_PAIRS = e00ld_pkg::DIGIT_PAIRS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic [6:0]  repeat_res,
  output logic        end_of_line,
  output logic [1:0]  error_code,
  output logic        last
);
  import e00ld_pkg::*;

  localparam int PC_W   = $clog2(DIGIT_PAIRS + 1);
  localparam int ADDR_W = $clog2(DIGIT_PAIRS);
  localparam int IDX_W  = $clog2(2 * DIGIT_PAIRS + 1);
  localparam int CMP_W  = (IDX_W > 5) ? IDX_W : 5;

  // control state
  state_t           state;
  state_t           state_next;
  mode_t            mode;
  logic [6:0]       line_limit;
  logic [6:0]       line_length;
  logic [PC_W-1:0]  pair_count;
  logic [3:0]       point_pos;
  logic             odd_digits;
  logic [1:0]       exp_mode;
  logic [1:0]       sticky;
  phase_t           phase;
  logic [IDX_W-1:0] idx;
  logic             term_space;

  // payload registers
  logic [7:0]       byte_r;
  logic [7:0]       emit_ch;
  logic [6:0]       emit_k;
  logic [6:0]       pair_store [DIGIT_PAIRS];

  // shared line room unit
  logic [6:0]       eu_k;
  emit_t            eu;

  // result path
  gen_ctl_t         gen_ctl;
  gen_ack_t         gen_ack;
  res_t             gen_res;

  dec_t             dec;
  logic             dec_go;
  hdr_t             hdr;

  // number expansion
  logic [IDX_W-1:0] used;
  logic [1:0]       expd;
  logic             short_num;
  logic [ADDR_W-1:0] pair_addr;
  logic [6:0]       pair_v;
  logic [3:0]       tens;
  logic [6:0]       ones;
  logic [7:0]       digit_ch;
  logic             exp_has;
  logic             exp_digit;
  logic             exp_done;
  logic [7:0]       exp_ch;
  phase_t           phase_next;
  logic             exp_step;

  logic             cfg_wr;

  // config port, single register at byte address zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LINE_LIMIT);
  assign prdata = (paddr == ADDR_LINE_LIMIT) ? {25'd0, line_limit} : 32'd0;

  assign eu_k = (state == S_EXPAND) ? 7'd1 : emit_k;

  e00ld_emit_unit u_emit (
    .line_length (line_length),
    .line_limit  (line_limit),
    .k           (eu_k),
    .eu          (eu)
  );

  e00ld_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .ctl         (gen_ctl),
    .gen_res     (gen_res),
    .ack         (gen_ack),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .repeat_res  (repeat_res),
    .end_of_line (end_of_line),
    .error_code  (error_code),
    .last        (last)
  );

  // number length check
  assign used      = IDX_W'({pair_count, 1'b0}) - IDX_W'(odd_digits);
  assign expd      = (exp_mode != 2'd0) ? 2'd2 : 2'd0;
  assign short_num = ((pair_count == '0) && odd_digits) ||
                     (CMP_W'(used) < (CMP_W'(point_pos) + CMP_W'(expd)));

  // digit read: even index is the tens digit, odd index the ones digit
  assign pair_addr = ADDR_W'(idx >> 1);
  assign pair_v    = pair_store[pair_addr];
  assign tens      = pair_tens(pair_v);
  assign ones      = pair_v - (7'(tens) * 7'd10);
  assign digit_ch  = CH_ZERO + 8'(idx[0] ? ones[3:0] : tens);

  assign hdr = hdr_split(7'(byte_r - CH_BANG));

  function automatic dec_t dec_err(input dec_t d, input logic [1:0] code);
    dec_t r;
    r           = d;
    r.act       = ACT_RESULT;
    r.res       = '0;
    r.res.err   = code;
    r.raise     = code;
    r.mode_next = MODE_PLAIN;
    return r;
  endfunction

  function automatic dec_t dec_emit(input dec_t d, input logic [7:0] ch,
                                    input logic [6:0] k);
    dec_t r;
    r           = d;
    r.act       = ACT_EMIT;
    r.emit_ch   = ch;
    r.emit_k    = k;
    r.mode_next = MODE_PLAIN;
    return r;
  endfunction

  function automatic dec_t dec_eol(input dec_t d);
    dec_t r;
    r            = d;
    r.act        = ACT_RESULT;
    r.res        = '0;
    r.res.eol    = 1'b1;
    r.line_clear = 1'b1;
    r.mode_next  = MODE_PLAIN;
    return r;
  endfunction

  // what one byte does in the current mode
  always_comb begin
    dec           = '0;
    dec.act       = ACT_NONE;
    dec.mode_next = mode;
    if (sticky != ERR_NONE) begin
      dec.act     = ACT_RESULT;
      dec.res.err = sticky;
    end else if (byte_r == CH_SUB || byte_r == CH_CR || byte_r == CH_LF) begin
      dec.act = ACT_NONE;
    end else begin
      case (mode)
        MODE_ESC: begin
          if (byte_r == CH_CLOSE) begin
            dec = dec_eol(dec);
          end else if (byte_r == CH_SPACE) begin
            dec.mode_next = MODE_RUN;
          end else if (byte_r == CH_TILDE) begin
            dec = dec_emit(dec, CH_TILDE, 7'd1);
          end else if (byte_r >= CH_BANG && byte_r < CH_BANG + 8'(HDR_SPAN)) begin
            dec.hdr_load  = 1'b1;
            dec.mode_next = MODE_NUM;
          end else begin
            dec = dec_err(dec, ERR_ESC);
          end
        end
        MODE_RUN, MODE_TAILRUN: begin
          if (byte_r < CH_SPACE || byte_r > RUN_MAX) begin
            dec = dec_err(dec, ERR_ESC);
          end else begin
            dec = dec_emit(dec, CH_SPACE, 7'(byte_r - CH_SPACE));
          end
        end
        MODE_NUM: begin
          if (byte_r == CH_SPACE || byte_r == CH_TILDE) begin
            if (short_num) begin
              dec = dec_err(dec, ERR_NUM);
            end else begin
              dec.act        = ACT_EXPAND;
              dec.term_space = (byte_r == CH_SPACE);
              dec.mode_next  = (byte_r == CH_TILDE) ? MODE_TAIL : MODE_PLAIN;
            end
          end else if (byte_r == CH_CLOSE) begin
            dec.mode_next = MODE_NUMHI;
          end else if (byte_r >= CH_BANG && byte_r <= CH_PIPE) begin
            if (pair_count >= PC_W'(DIGIT_PAIRS)) begin
              dec = dec_err(dec, ERR_NUM);
            end else begin
              dec.pair_wr  = 1'b1;
              dec.pair_val = 7'(byte_r - CH_BANG);
            end
          end else begin
            dec = dec_err(dec, ERR_NUM);
          end
        end
        MODE_NUMHI: begin
          if (byte_r >= CH_BANG && byte_r <= CH_PAREN) begin
            if (pair_count >= PC_W'(DIGIT_PAIRS)) begin
              dec = dec_err(dec, ERR_NUM);
            end else begin
              dec.mode_next = MODE_NUM;
              dec.pair_wr   = 1'b1;
              dec.pair_val  = 7'(byte_r - CH_BANG) + PAIR_HI_BASE;
            end
          end else begin
            dec = dec_err(dec, ERR_NUM);
          end
        end
        MODE_TAIL: begin
          if (byte_r == CH_CLOSE) begin
            dec = dec_eol(dec);
          end else if (byte_r == CH_SPACE) begin
            dec.mode_next = MODE_TAILRUN;
          end else begin
            dec = dec_emit(dec, byte_r, 7'd1);
          end
        end
        default: begin
          // plain copy, also the unused mode code
          if (byte_r == CH_TILDE) begin
            dec.mode_next = MODE_ESC;
          end else begin
            dec = dec_emit(dec, byte_r, 7'd1);
          end
        end
      endcase
    end
  end

  assign dec_go = (dec.act != ACT_RESULT) || gen_ack.taken;

  // expansion walk: leading digits, point, remaining digits, exponent, space
  always_comb begin
    exp_has    = 1'b0;
    exp_digit  = 1'b0;
    exp_done   = 1'b0;
    exp_ch     = digit_ch;
    phase_next = phase;
    case (phase)
      PH_INT: begin
        if (CMP_W'(idx) < CMP_W'(point_pos)) begin
          exp_has   = 1'b1;
          exp_digit = 1'b1;
        end else begin
          phase_next = PH_DOT;
        end
      end
      PH_DOT: begin
        exp_has    = (point_pos != 4'd0);
        exp_ch     = CH_DOT;
        phase_next = PH_FRAC;
      end
      PH_FRAC: begin
        if (CMP_W'(idx) + CMP_W'(expd) < CMP_W'(used)) begin
          exp_has   = 1'b1;
          exp_digit = 1'b1;
        end else begin
          phase_next = PH_E;
        end
      end
      PH_E: begin
        exp_has    = (exp_mode != 2'd0);
        exp_ch     = CH_E;
        phase_next = (exp_mode != 2'd0) ? PH_SIGN : PH_SPACE;
      end
      PH_SIGN: begin
        exp_has    = 1'b1;
        exp_ch     = (exp_mode == 2'd1) ? CH_PLUS : CH_MINUS;
        phase_next = PH_EXP;
      end
      PH_EXP: begin
        if (idx < used) begin
          exp_has   = 1'b1;
          exp_digit = 1'b1;
        end else begin
          phase_next = PH_SPACE;
        end
      end
      PH_SPACE: begin
        exp_has  = term_space;
        exp_ch   = CH_SPACE;
        exp_done = 1'b1;
      end
      default: begin
        exp_done = 1'b1;
      end
    endcase
  end

  assign exp_step = !exp_has || gen_ack.taken;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (dec.act)
          ACT_RESULT: if (gen_ack.taken) state_next = S_FLUSH;
          ACT_EMIT:   state_next = S_EMIT;
          ACT_EXPAND: state_next = S_EXPAND;
          default:    state_next = S_FLUSH;
        endcase
      end
      S_EMIT: begin
        if (emit_k == 7'd0) begin
          state_next = S_FLUSH;
        end else if (gen_ack.taken) begin
          // a cut run still owes the overflow error
          state_next = (eu.fits || eu.grant == 7'd0) ? S_FLUSH : S_ERR;
        end
      end
      S_ERR: begin
        if (gen_ack.taken) state_next = S_FLUSH;
      end
      S_EXPAND: begin
        if (exp_step && ((exp_has && !eu.fits) || exp_done)) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (gen_ack.flushed) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready        = (state == S_IDLE);
    gen_ctl         = '0;
    gen_res         = '0;
    case (state)
      S_DECODE: begin
        gen_ctl.valid = (dec.act == ACT_RESULT);
        gen_res       = dec.res;
      end
      S_EMIT: begin
        gen_ctl.valid = (emit_k != 7'd0);
        if (eu.grant != 7'd0) begin
          gen_res.ch  = emit_ch;
          gen_res.rep = eu.grant;
        end else begin
          gen_res.err = ERR_LONG;
        end
      end
      S_ERR: begin
        gen_ctl.valid = 1'b1;
        gen_res.err   = ERR_LONG;
      end
      S_EXPAND: begin
        gen_ctl.valid = exp_has;
        if (eu.fits) begin
          gen_res.ch  = exp_ch;
          gen_res.rep = 7'd1;
        end else begin
          gen_res.err = ERR_LONG;
        end
      end
      S_FLUSH: begin
        gen_ctl.end_req = 1'b1;
      end
      default: begin
        gen_ctl = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_PLAIN;
      line_limit  <= LINE_LIMIT_RESET;
      line_length <= 7'd0;
      pair_count  <= '0;
      point_pos   <= 4'd0;
      odd_digits  <= 1'b0;
      exp_mode    <= 2'd0;
      sticky      <= ERR_NONE;
      phase       <= PH_INT;
      idx         <= '0;
      term_space  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) line_limit <= pwdata[6:0];
      case (state)
        S_DECODE: begin
          if (dec_go) begin
            mode <= dec.mode_next;
            if (dec.raise != ERR_NONE) sticky <= dec.raise;
            if (dec.line_clear) line_length <= 7'd0;
            if (dec.hdr_load) begin
              point_pos  <= hdr.pp;
              odd_digits <= hdr.odd;
              exp_mode   <= hdr.expm;
              pair_count <= '0;
            end
            if (dec.pair_wr) pair_count <= pair_count + PC_W'(1);
            if (dec.act == ACT_EXPAND) begin
              phase      <= PH_INT;
              idx        <= '0;
              term_space <= dec.term_space;
            end
          end
        end
        S_EMIT: begin
          if (emit_k != 7'd0 && gen_ack.taken) begin
            line_length <= eu.length_next;
            if (eu.grant == 7'd0) sticky <= ERR_LONG;
          end
        end
        S_ERR: begin
          if (gen_ack.taken) sticky <= ERR_LONG;
        end
        S_EXPAND: begin
          if (exp_step) begin
            if (exp_has && !eu.fits) begin
              sticky <= ERR_LONG;
            end else begin
              if (exp_has) line_length <= eu.length_next;
              if (exp_has && exp_digit) idx <= idx + IDX_W'(1);
              phase <= phase_next;
            end
          end
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

  // payload registers and digit pair buffer
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) byte_r <= in_byte;
    if (state == S_DECODE) begin
      emit_ch <= dec.emit_ch;
      emit_k  <= dec.emit_k;
      if (dec.pair_wr) pair_store[pair_count[ADDR_W-1:0]] <= dec.pair_val;
    end
  end

endmodule

// ===== tb/e00_line_decompressor_tb.sv =====
`timescale 1ns / 100ps

module e00_line_decompressor_tb;
  import e00ld_pkg::*;

  // cycles allowed for a byte that gives no result to settle before a register write
  localparam int SETTLE_CYCLES = 24;
  // stream bytes per line limit setting
  localparam int PHASE_ITEMS = 24;

  // opening stream: extreme plain bytes, dropped bytes, literal tilde, empty and
  // short space runs, end of line, a number with no digits closed by '~' and an
  // end of line tail, then an exponent-only number with a high pair and a space
  localparam logic [7:0] OPENING [25] = '{
    8'h41, 8'h00, 8'hff, CH_SUB, CH_CR, CH_LF,
    CH_TILDE, CH_TILDE,
    CH_TILDE, CH_SPACE, CH_SPACE,
    CH_TILDE, CH_SPACE, 8'd66,
    CH_TILDE, CH_CLOSE,
    CH_TILDE, CH_BANG, CH_TILDE, CH_CLOSE,
    CH_TILDE, 8'd48, CH_CLOSE, CH_PAREN, CH_SPACE
  };

  typedef struct {
    logic [7:0] ch;
    logic [6:0] rep;
    logic       eol;
    logic [1:0] err;
    logic       last;
  } dec_res_t;

  // ways the stream is finally broken, one per run
  typedef enum int {
    BREAK_OVERFLOW,
    BREAK_ESCAPE,
    BREAK_RUN_COUNT,
    BREAK_DIGIT,
    BREAK_HI_DIGIT,
    BREAK_PAIRS,
    BREAK_SHORT
  } break_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic [6:0]  repeat_res;
  logic        end_of_line;
  logic [1:0]  error_code;
  logic        last;

  e00_line_decompressor #(
    .DIGIT_PAIRS(DIGIT_PAIRS_DEF)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .repeat_res  (repeat_res),
    .end_of_line (end_of_line),
    .error_code  (error_code),
    .last        (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // decoder state mirror plus the queue of characters still owed by the block
  class decoded_char_board;
    int         limit;
    mode_t      mode;
    int         line_len;
    logic [6:0] pairs [DIGIT_PAIRS_DEF];
    int         pair_cnt;
    int         point_pos;
    int         odd;
    int         exp_mode;
    logic [1:0] sticky;
    dec_res_t   due[$];
    dec_res_t   fresh[$];
    int         fails;
    int         checked;

    function new();
      limit     = LINE_LIMIT_RESET;
      mode      = MODE_PLAIN;
      line_len  = 0;
      pair_cnt  = 0;
      point_pos = 0;
      odd       = 0;
      exp_mode  = 0;
      sticky    = ERR_NONE;
      fails     = 0;
      checked   = 0;
      foreach (pairs[i]) pairs[i] = '0;
    endfunction

    function void put(logic [7:0] ch, logic [6:0] rep, logic eol, logic [1:0] err);
      dec_res_t r;
      if (fresh.size() >= 52) return;
      r.ch   = ch;
      r.rep  = rep;
      r.eol  = eol;
      r.err  = err;
      r.last = 1'b0;
      fresh.push_back(r);
    endfunction

    // first error is reported once, later ones only reset the mode
    function void raise_err(logic [1:0] e);
      if (sticky == ERR_NONE) begin
        sticky = e;
        put(8'd0, 7'd0, 1'b0, e);
      end
      mode = MODE_PLAIN;
    endfunction

    // give out k copies of ch, cut to the room left on the line
    function void emit(logic [7:0] ch, int k);
      int room;
      if (sticky != ERR_NONE || k == 0) return;
      room = (line_len < limit) ? limit - line_len : 0;
      if (k > room) begin
        if (room > 0) begin
          put(ch, 7'(room), 1'b0, ERR_NONE);
          line_len += room;
        end
        raise_err(ERR_LONG);
        return;
      end
      put(ch, 7'(k), 1'b0, ERR_NONE);
      line_len += k;
    endfunction

    function void end_line();
      put(8'd0, 7'd0, 1'b1, ERR_NONE);
      line_len = 0;
      mode     = MODE_PLAIN;
    endfunction

    function void store_pair(int v);
      if (pair_cnt >= DIGIT_PAIRS_DEF) begin
        raise_err(ERR_NUM);
        return;
      end
      pairs[pair_cnt] = 7'(v);
      pair_cnt++;
    endfunction

    // digit i of the buffered number, two per stored pair
    function logic [7:0] digit(int i);
      logic [6:0] v;
      v = pairs[(i / 2) % DIGIT_PAIRS_DEF];
      return CH_ZERO + 8'((i % 2 != 0) ? v % 7'd10 : v / 7'd10);
    endfunction

    function void take_byte(logic [7:0] b);
      int n, used, expd, idx, m;
      fresh.delete();
      if (sticky != ERR_NONE) begin
        put(8'd0, 7'd0, 1'b0, sticky);
      end else if (b == CH_SUB || b == CH_LF || b == CH_CR) begin
        // dropped in every mode
      end else begin
        case (mode)
          MODE_ESC: begin
            if (b == CH_CLOSE) begin
              end_line();
            end else if (b == CH_SPACE) begin
              mode = MODE_RUN;
            end else if (b == CH_TILDE) begin
              emit(CH_TILDE, 1);
              mode = MODE_PLAIN;
            end else if (b >= CH_BANG && b < CH_BANG + HDR_SPAN) begin
              n         = b - CH_BANG;
              point_pos = n % HDR_GROUP;
              odd       = n / ODD_SPLIT;
              exp_mode  = (n / HDR_GROUP) % EXP_MODES;
              pair_cnt  = 0;
              mode      = MODE_NUM;
            end else begin
              raise_err(ERR_ESC);
            end
          end
          MODE_RUN, MODE_TAILRUN: begin
            mode = MODE_PLAIN;
            if (b < CH_SPACE || b > RUN_MAX) raise_err(ERR_ESC);
            else emit(CH_SPACE, b - CH_SPACE);
          end
          MODE_NUM: begin
            if (b == CH_SPACE || b == CH_TILDE) begin
              // terminator: expand the buffered digits
              used = 2 * pair_cnt - odd;
              expd = (exp_mode != 0) ? 2 : 0;
              if (2 * pair_cnt < odd || used < point_pos + expd) begin
                raise_err(ERR_NUM);
              end else begin
                idx = 0;
                m   = used - point_pos - expd;
                if (point_pos != 0) begin
                  for (int i = 0; i < point_pos; i++) begin
                    emit(digit(idx), 1);
                    idx++;
                  end
                  emit(CH_DOT, 1);
                end
                for (int i = 0; i < m; i++) begin
                  emit(digit(idx), 1);
                  idx++;
                end
                if (expd != 0) begin
                  emit(CH_E, 1);
                  emit((exp_mode == 1) ? CH_PLUS : CH_MINUS, 1);
                  emit(digit(idx), 1);
                  emit(digit(idx + 1), 1);
                end
                if (b == CH_SPACE) begin
                  emit(CH_SPACE, 1);
                  mode = MODE_PLAIN;
                end else begin
                  mode = MODE_TAIL;
                end
              end
            end else if (b == CH_CLOSE) begin
              mode = MODE_NUMHI;
            end else if (b >= CH_BANG && b <= CH_PIPE) begin
              store_pair(b - CH_BANG);
            end else begin
              raise_err(ERR_NUM);
            end
          end
          MODE_NUMHI: begin
            if (b >= CH_BANG && b <= CH_PAREN) begin
              mode = MODE_NUM;
              store_pair(PAIR_HI_BASE + b - CH_BANG);
            end else begin
              raise_err(ERR_NUM);
            end
          end
          MODE_TAIL: begin
            if (b == CH_CLOSE) begin
              end_line();
            end else if (b == CH_SPACE) begin
              mode = MODE_TAILRUN;
            end else begin
              emit(b, 1);
              mode = MODE_PLAIN;
            end
          end
          default: begin
            if (b == CH_TILDE) begin
              mode = MODE_ESC;
            end else begin
              mode = MODE_PLAIN;
              emit(b, 1);
            end
          end
        endcase
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) due.push_back(fresh[i]);
    endfunction

    function int miss(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void match_result(logic [7:0] ch, logic [6:0] rep, logic eol,
                               logic [1:0] err, logic lst);
      dec_res_t e;
      checked++;
      if (due.size() == 0) begin
        $error("result with nothing pending: char %0d repeat %0d eol %0d error %0d",
               ch, rep, eol, err);
        fails++;
        return;
      end
      e = due.pop_front();
      fails += miss("out_char", e.ch, ch);
      fails += miss("repeat_res", 8'(e.rep), 8'(rep));
      fails += miss("end_of_line", 8'(e.eol), 8'(eol));
      fails += miss("error_code", 8'(e.err), 8'(err));
      fails += miss("last", 8'(e.last), 8'(lst));
    endfunction
  endclass

  decoded_char_board board;
  logic [7:0] tok[$];
  int         burst_left = 0;
  int         items = 0;
  int         reg_read_errs = 0;
  int         ready_style = 0;
  int         ready_left = 0;

  // result side: check each transfer, then pick the next ready value from a
  // stall pattern that is itself redrawn at random
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      board.match_result(out_char, repeat_res, end_of_line, error_code, last);
    if (ready_left == 0) begin
      ready_style = $urandom_range(0, 3);
      ready_left  = $urandom_range(20, 120);
    end
    ready_left--;
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  function automatic bit is_dropped(logic [7:0] b);
    return b == CH_SUB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic [7:0] dropped_byte();
    case ($urandom_range(0, 2))
      0: return CH_SUB;
      1: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // digit pair as one code byte, or the close brace prefix for the high ones
  function automatic void add_pair(int v);
    if (v < PAIR_HI_BASE) begin
      tok.push_back(CH_BANG + 8'(v));
    end else begin
      tok.push_back(CH_CLOSE);
      tok.push_back(CH_BANG + 8'(v - PAIR_HI_BASE));
    end
  endfunction

  // one well-formed piece of stream in tok, returns the characters it puts on
  // the line; never more than budget
  function automatic int build_token(int budget);
    int pick, h, pp, odd, expd, pcmin, pc, chars, c;
    logic [7:0] b;
    tok.delete();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      h     = $urandom_range(0, HDR_SPAN - 1);
      pp    = h % HDR_GROUP;
      odd   = h / ODD_SPLIT;
      expd  = ((h / HDR_GROUP) % EXP_MODES != 0) ? 2 : 0;
      pcmin = (pp + expd + odd + 1) / 2;
      // mostly short numbers, now and then up to a full pair buffer
      pc    = ($urandom_range(0, 7) == 0) ? $urandom_range(pcmin, DIGIT_PAIRS_DEF)
                                          : pcmin + $urandom_range(0, 2);
      chars = 2 * pc - odd + ((pp != 0) ? 1 : 0) + expd;
      tok.push_back(CH_TILDE);
      tok.push_back(CH_BANG + 8'(h));
      repeat (pc) add_pair($urandom_range(0, 99));
      if ($urandom_range(0, 1) != 0) begin
        tok.push_back(CH_SPACE);
        chars++;
      end else begin
        // tilde terminator, then the tail byte
        tok.push_back(CH_TILDE);
        case ($urandom_range(0, 2))
          0: tok.push_back(CH_CLOSE);
          1: begin
            c = $urandom_range(0, 6);
            tok.push_back(CH_SPACE);
            tok.push_back(CH_SPACE + 8'(c));
            chars += c;
          end
          default: begin
            do b = 8'($urandom_range(0, 255));
            while (is_dropped(b) || b == CH_SPACE || b == CH_CLOSE);
            tok.push_back(b);
            chars++;
          end
        endcase
      end
      if (chars <= budget) return chars;
      // too wide for this limit, fall back to a plain char
      tok.delete();
      pick = 0;
    end
    if (pick < 70) begin
      do b = 8'($urandom_range(0, 255));
      while (is_dropped(b) || b == CH_TILDE);
      tok.push_back(b);
      return 1;
    end
    if (pick < 78) begin
      tok.push_back(CH_TILDE);
      tok.push_back(CH_TILDE);
      return 1;
    end
    if (pick < 90) begin
      c = $urandom_range(0, ($urandom_range(0, 3) == 0) ? RUN_MAX - CH_SPACE : 6);
      if (c > budget) c = budget;
      tok.push_back(CH_TILDE);
      tok.push_back(CH_SPACE);
      tok.push_back(CH_SPACE + 8'(c));
      return c;
    end
    tok.push_back(CH_TILDE);
    tok.push_back(CH_CLOSE);
    return 0;
  endfunction

  // sender works in bursts; valid drops when a burst ends or input is stopped
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    board.take_byte(b);
    if (!is_dropped(b)) items++;
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // send tok with the odd dropped byte slipped in anywhere
  task automatic send_tok();
    logic [7:0] bytes[$];
    bytes = tok;
    foreach (bytes[i]) begin
      if ($urandom_range(0, 15) == 0) send_byte(dropped_byte());
      send_byte(bytes[i]);
    end
  endtask

  task automatic stop_input();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic apb_write(logic [6:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LINE_LIMIT;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(output logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LINE_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // close the line, let the block go idle, then set and read back the limit
  task automatic change_limit(int v);
    logic [31:0] rd;
    if (board.line_len != 0) begin
      send_byte(CH_TILDE);
      send_byte(CH_CLOSE);
    end
    stop_input();
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(7'(v));
    apb_read(rd);
    if (rd !== 32'(v)) begin
      $error("line_limit: expected %0d, got %0d", v, rd);
      reg_read_errs++;
    end
    board.limit = v;
  endtask

  initial begin
    int         phase_limit [6];
    int         start, chars, h, pp, odd, expd, pcmin;
    logic [7:0] b;
    break_t     kind;
    board = new();
    phase_limit = '{int'(LINE_LIMIT_RESET), 127, 1, $urandom_range(2, 40), 127,
                    $urandom_range(41, 126)};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_byte(OPENING[i]);

    // random stream under each line limit, the reset value first
    for (int p = 0; p < 6; p++) begin
      if (p != 0) change_limit(phase_limit[p]);
      start = items;
      while (items - start < PHASE_ITEMS) begin
        chars = build_token(board.limit);
        if (chars > board.limit - board.line_len) begin
          send_byte(CH_TILDE);
          send_byte(CH_CLOSE);
        end
        send_tok();
      end
    end

    // errors are sticky until reset, so only one kind can close the run
    kind = break_t'($urandom_range(0, 6));
    tok.delete();
    case (kind)
      BREAK_OVERFLOW: begin
        // a limit of zero makes the very first character an error
        if ($urandom_range(0, 1) != 0) change_limit($urandom_range(0, 127));
        while (board.sticky == ERR_NONE) begin
          if ($urandom_range(0, 1) != 0) begin
            send_byte(CH_TILDE);
            send_byte(CH_SPACE);
            send_byte(CH_SPACE + 8'($urandom_range(1, RUN_MAX - CH_SPACE)));
          end else begin
            send_byte(8'h78);
          end
        end
      end
      BREAK_ESCAPE: begin
        do b = 8'($urandom_range(0, 255));
        while (is_dropped(b) || b == CH_CLOSE || b == CH_SPACE || b == CH_TILDE ||
               (b >= CH_BANG && b < CH_BANG + HDR_SPAN));
        tok = '{CH_TILDE, b};
      end
      BREAK_RUN_COUNT: begin
        // either a plain run or a run after a tilde-terminated empty number
        if ($urandom_range(0, 1) != 0) tok = '{CH_TILDE, CH_BANG, CH_TILDE, CH_SPACE};
        else tok = '{CH_TILDE, CH_SPACE};
        do b = 8'($urandom_range(0, 255));
        while (is_dropped(b) || (b >= CH_SPACE && b <= RUN_MAX));
        tok.push_back(b);
      end
      BREAK_DIGIT: begin
        tok = '{CH_TILDE, CH_BANG + 8'($urandom_range(0, HDR_SPAN - 1))};
        repeat ($urandom_range(0, 3)) add_pair($urandom_range(0, 99));
        do b = 8'($urandom_range(0, 255));
        while (is_dropped(b) || (b >= CH_SPACE && b <= CH_TILDE));
        tok.push_back(b);
      end
      BREAK_HI_DIGIT: begin
        tok = '{CH_TILDE, CH_BANG + 8'($urandom_range(0, HDR_SPAN - 1)), CH_CLOSE};
        do b = 8'($urandom_range(0, 255));
        while (is_dropped(b) || (b >= CH_BANG && b <= CH_PAREN));
        tok.push_back(b);
      end
      BREAK_PAIRS: begin
        tok = '{CH_TILDE, CH_BANG + 8'($urandom_range(0, HDR_SPAN - 1))};
        repeat (DIGIT_PAIRS_DEF + 1) add_pair($urandom_range(0, 99));
      end
      default: begin
        // fewer digits than the point position and exponent need
        do begin
          h    = $urandom_range(0, HDR_SPAN - 1);
          pp   = h % HDR_GROUP;
          odd  = h / ODD_SPLIT;
          expd = ((h / HDR_GROUP) % EXP_MODES != 0) ? 2 : 0;
        end while (pp + expd + odd == 0);
        pcmin = (pp + expd + odd + 1) / 2;
        tok = '{CH_TILDE, CH_BANG + 8'(h)};
        repeat ($urandom_range(0, pcmin - 1)) add_pair($urandom_range(0, 99));
        tok.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TILDE);
      end
    endcase
    send_tok();

    // every later byte, dropped ones too, repeats the error
    send_byte(dropped_byte());
    repeat (7) send_byte(8'($urandom_range(0, 255)));
    stop_input();

    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("decoded %0d stream bytes under line limits %0d %0d %0d %0d %0d %0d",
             items, phase_limit[0], phase_limit[1], phase_limit[2], phase_limit[3],
             phase_limit[4], phase_limit[5]);
    $display("checked %0d result transfers, stream closed by %s", board.checked,
             kind.name());
    if (board.fails == 0 && reg_read_errs == 0 && board.due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
